FILE: rtl/cabm_pkg.sv
// Shared types and constants for the comment-aware brace matcher.
// No dependencies; imported by the lexer, the top level, the checker and the testbench top.
package cabm_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int LINE_BITS_DEF   = 20;
  localparam int INDEX_BITS_DEF  = 16;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_CLOSED    = 2'd0,
    KIND_INSIDE    = 2'd1,
    KIND_UNMATCHED = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  // What the lexer hands to the stack logic for one word
  typedef enum logic [1:0] {
    EVT_NONE,
    EVT_NEWLINE,
    EVT_OPEN,
    EVT_CLOSE
  } lex_evt_t;

  typedef struct packed {
    logic block;
    logic linec;
    logic chr;
    logic str;
  } lex_flags_t;

  typedef struct packed {
    logic slash;
    logic star;
    logic esc;
  } pend_flags_t;

endpackage

FILE: rtl/comment_aware_brace_matcher.sv
// Comment-aware brace matcher: lexer, top-of-stack register, stack memory.
// A result sits in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; input stalls only while a result waits unread.
// The entry under the top is prefetched from the stack memory every cycle,
// so a pop followed at once by another pop or newline needs no bubble.
// Reset (or first on a byte) clears lexer, ordinal and level and sets the line to 1; no clearing pass.
module comment_aware_brace_matcher #(
  parameter int STACK_DEPTH = cabm_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BITS   = cabm_pkg::LINE_BITS_DEF,
  parameter int INDEX_BITS  = cabm_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  first,
  input  logic [7:0]            byte_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [INDEX_BITS-1:0] brace_index,
  output logic [LINE_BITS-1:0]  open_line,
  output logic [LINE_BITS-1:0]  line
);
  import cabm_pkg::*;

  localparam int LW     = $clog2(STACK_DEPTH + 1);
  localparam int MDEPTH = STACK_DEPTH - 1;
  localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int DW     = INDEX_BITS + LINE_BITS;

  logic                  in_acc;
  lex_evt_t              evt;
  logic [LINE_BITS-1:0]  line_cur;

  logic [LW-1:0]         level, level_next, lvl_e, lvl_dec, lvl_inc, lvl_m2;
  logic [INDEX_BITS-1:0] opened, opened_next, ord_e;
  logic [INDEX_BITS-1:0] top_ord, top_ord_next;
  logic [LINE_BITS-1:0]  top_line, top_line_next;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DW-1:0]         wdata, rdata;

  logic                  res;
  kind_t                 kind_n;
  logic [INDEX_BITS-1:0] idx_n;
  logic [LINE_BITS-1:0]  ol_n;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  cabm_lexer #(.LINE_BITS(LINE_BITS)) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_acc),
    .first    (first),
    .byte_req (byte_req),
    .evt      (evt),
    .line_cur (line_cur)
  );

  cabm_stack_mem #(.WIDTH(DW), .DEPTH(MDEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lvl_e   = first ? '0 : level;
  assign ord_e   = first ? '0 : opened;
  assign lvl_dec = lvl_e - LW'(1);
  assign lvl_inc = lvl_e + LW'(1);
  assign waddr   = lvl_dec[AW-1:0];
  assign wdata   = {top_ord, top_line};

  always_comb begin
    level_next    = level;
    opened_next   = opened;
    top_ord_next  = top_ord;
    top_line_next = top_line;
    we            = 1'b0;
    res           = 1'b0;
    kind_n        = KIND_CLOSED;
    idx_n         = '0;
    ol_n          = '0;

    if (in_acc) begin
      level_next  = lvl_e;
      opened_next = ord_e;
      case (evt)
        EVT_NEWLINE: begin
          if (lvl_e != '0) begin
            res    = 1'b1;
            kind_n = KIND_INSIDE;
            idx_n  = top_ord;
            ol_n   = top_line;
          end
        end
        EVT_OPEN: begin
          opened_next = ord_e + INDEX_BITS'(1);
          if (lvl_e == LW'(STACK_DEPTH)) begin
            res    = 1'b1;
            kind_n = KIND_OVERFLOW;
            idx_n  = ord_e;
            ol_n   = line_cur;
          end else begin
            // spill the old top into memory, new entry becomes the top
            we            = (lvl_e != '0);
            top_ord_next  = ord_e;
            top_line_next = line_cur;
            level_next    = lvl_inc;
          end
        end
        EVT_CLOSE: begin
          res = 1'b1;
          if (lvl_e == '0) begin
            kind_n = KIND_UNMATCHED;
          end else begin
            kind_n        = KIND_CLOSED;
            idx_n         = top_ord;
            ol_n          = top_line;
            top_ord_next  = rdata[DW-1 -: INDEX_BITS];
            top_line_next = rdata[LINE_BITS-1:0];
            level_next    = lvl_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // prefetch the entry under the next top
  assign lvl_m2 = level_next - LW'(2);
  assign raddr  = (level_next >= LW'(2)) ? lvl_m2[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      opened <= '0;
    end else begin
      level  <= level_next;
      opened <= opened_next;
    end
  end

  always_ff @(posedge clk) begin
    top_ord  <= top_ord_next;
    top_line <= top_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res) begin
      kind        <= kind_n;
      brace_index <= idx_n;
      open_line   <= ol_n;
      line        <= line_cur;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    in_acc && evt == EVT_CLOSE && lvl_e != '0 |=> level == $past(lvl_dec))
    else $error("pop did not lower the level by one");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    in_acc && evt == EVT_OPEN && lvl_e != LW'(STACK_DEPTH)
    |=> top_ord == $past(ord_e) && top_line == $past(line_cur) && level == $past(lvl_inc))
    else $error("push did not load the top entry");

  a_overflow_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_OVERFLOW |-> open_line == line)
    else $error("overflow result with differing lines");

  a_free_slot_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

FILE: rtl/cabm_lexer.sv
// Lexer context tracker: comments, literals, escapes and the line counter.
// Depends on cabm_pkg; flags a code-context newline or brace to the stack logic.
module cabm_lexer #(
  parameter int LINE_BITS = cabm_pkg::LINE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    first,
  input  logic [7:0]              byte_req,
  output cabm_pkg::lex_evt_t      evt,
  output logic [LINE_BITS-1:0]    line_cur
);
  import cabm_pkg::*;

  lex_flags_t           flags, fl, fl_next;
  pend_flags_t          pend, pd, pd_next;
  logic [LINE_BITS-1:0] line_cnt, lc;
  logic                 code_tail;

  always_comb begin
    fl        = first ? '0 : flags;
    pd        = first ? '0 : pend;
    lc        = first ? LINE_BITS'(1) : line_cnt;
    fl_next   = fl;
    pd_next   = pd;
    code_tail = 1'b0;
    evt       = EVT_NONE;

    // every newline counts once, saturating
    if (byte_req == CH_NL && lc != '1) lc = lc + LINE_BITS'(1);

    if (fl.block) begin
      if (pd.star && byte_req == CH_SLASH) begin
        fl_next.block = 1'b0;
        pd_next       = '0;
      end else begin
        pd_next      = '0;
        pd_next.star = (byte_req == CH_STAR);
      end
    end else if (fl.linec) begin
      if (byte_req == CH_NL) begin
        fl_next.linec = 1'b0;
        pd_next       = '0;
        code_tail     = 1'b1;
      end
    end else if (fl.chr || fl.str) begin
      pd_next = '0;
      if (!pd.esc) begin
        if (byte_req == CH_BSL) pd_next.esc = 1'b1;
        else if (byte_req == CH_SQ && !fl.str) fl_next.chr = 1'b0;
        else if (byte_req == CH_DQ && !fl.chr) fl_next.str = 1'b0;
      end
    end else begin
      pd_next   = '0;
      code_tail = 1'b1;
      if (pd.slash && byte_req == CH_SLASH) begin
        fl_next.linec = 1'b1;
        code_tail     = 1'b0;
      end else if (pd.slash && byte_req == CH_STAR) begin
        fl_next.block = 1'b1;
        code_tail     = 1'b0;
      end else begin
        case (byte_req)
          CH_SLASH: begin
            pd_next.slash = 1'b1;
            code_tail     = 1'b0;
          end
          CH_SQ: begin
            fl_next.chr = 1'b1;
            code_tail   = 1'b0;
          end
          CH_DQ: begin
            fl_next.str = 1'b1;
            code_tail   = 1'b0;
          end
          default: ;
        endcase
      end
    end

    if (code_tail) begin
      case (byte_req)
        CH_NL:     evt = EVT_NEWLINE;
        CH_LBRACE: evt = EVT_OPEN;
        CH_RBRACE: evt = EVT_CLOSE;
        default:   evt = EVT_NONE;
      endcase
    end

    line_cur = lc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      pend     <= '0;
      line_cnt <= LINE_BITS'(1);
    end else if (accept) begin
      flags    <= fl_next;
      pend     <= pd_next;
      line_cnt <= lc;
    end
  end

endmodule

FILE: rtl/cabm_stack_mem.sv
// Stack storage below the top entry: one write port, one read port,
// registered read with write-to-read bypass on a same-address collision.
module cabm_stack_mem #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] byp_data;
  logic             byp;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q     <= mem[raddr];
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) byp <= 1'b0;
    else     byp <= we && (waddr == raddr);
  end

  assign rdata = byp ? byp_data : rd_q;

endmodule

FILE: tb/sv/brace_report_checker.sv
`timescale 1ns / 1ps
// Checker for the comment-aware brace matcher: watches both word channels,
// predicts each report from the accepted source bytes and compares in order.
// Depends on cabm_pkg for character codes, report kinds and lexer flag types.
module brace_report_checker #(
  parameter int STACK_DEPTH = cabm_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BITS   = cabm_pkg::LINE_BITS_DEF,
  parameter int INDEX_BITS  = cabm_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  first,
  input  logic [7:0]            byte_req,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            kind,
  input  logic [INDEX_BITS-1:0] brace_index,
  input  logic [LINE_BITS-1:0]  open_line,
  input  logic [LINE_BITS-1:0]  line,
  output int                    fail_count,
  output int                    pending
);
  import cabm_pkg::*;

  typedef struct packed {
    kind_t                 kind;
    logic [INDEX_BITS-1:0] idx;
    logic [LINE_BITS-1:0]  oline;
    logic [LINE_BITS-1:0]  lnum;
  } brace_report_t;

  brace_report_t awaited_reports[$];
  brace_report_t want;

  lex_flags_t            lx;
  pend_flags_t           pd;
  logic [LINE_BITS-1:0]  line_cnt;
  logic [INDEX_BITS-1:0] opened;
  logic [INDEX_BITS-1:0] stk_ord [STACK_DEPTH];
  logic [LINE_BITS-1:0]  stk_line [STACK_DEPTH];
  int                    depth;

  task automatic reset_scan();
    lx       = '0;
    pd       = '0;
    line_cnt = LINE_BITS'(1);
    opened   = '0;
    depth    = 0;
  endtask

  task automatic add_report(input kind_t k, input logic [INDEX_BITS-1:0] idx,
                            input logic [LINE_BITS-1:0] oline);
    brace_report_t r;
    r.kind  = k;
    r.idx   = idx;
    r.oline = oline;
    r.lnum  = line_cnt;
    awaited_reports = {awaited_reports, r};
  endtask

  // Advance the lexer and the brace stack by one source byte.
  task automatic scan_byte(input logic f, input logic [7:0] b);
    logic [INDEX_BITS-1:0] ord;
    if (f) reset_scan();
    if (b == CH_NL && line_cnt != {LINE_BITS{1'b1}}) line_cnt = line_cnt + 1'b1;

    if (lx.block) begin
      if (pd.star && b == CH_SLASH) begin
        lx.block = 1'b0;
        pd       = '0;
      end else begin
        pd      = '0;
        pd.star = (b == CH_STAR);
      end
      return;
    end

    if (lx.linec) begin
      if (b != CH_NL) return;
      // the terminating newline falls through as a code newline
      lx.linec = 1'b0;
      pd       = '0;
    end else if (lx.chr || lx.str) begin
      if (pd.esc) begin
        pd = '0;
        return;
      end
      pd = '0;
      if (b == CH_BSL) pd.esc = 1'b1;
      else if (b == CH_SQ && !lx.str) lx.chr = 1'b0;
      else if (b == CH_DQ && !lx.chr) lx.str = 1'b0;
      return;
    end else begin
      if (pd.slash) begin
        pd = '0;
        if (b == CH_SLASH) begin
          lx.linec = 1'b1;
          return;
        end
        if (b == CH_STAR) begin
          lx.block = 1'b1;
          return;
        end
      end
      pd = '0;
      if (b == CH_SLASH) begin
        pd.slash = 1'b1;
        return;
      end
      if (b == CH_SQ) begin
        lx.chr = 1'b1;
        return;
      end
      if (b == CH_DQ) begin
        lx.str = 1'b1;
        return;
      end
    end

    case (b)
      CH_NL: begin
        if (depth != 0) add_report(KIND_INSIDE, stk_ord[depth-1], stk_line[depth-1]);
      end
      CH_LBRACE: begin
        ord    = opened;
        opened = opened + 1'b1;
        if (depth >= STACK_DEPTH) begin
          add_report(KIND_OVERFLOW, ord, line_cnt);
        end else begin
          stk_ord[depth]  = ord;
          stk_line[depth] = line_cnt;
          depth++;
        end
      end
      CH_RBRACE: begin
        if (depth == 0) begin
          add_report(KIND_UNMATCHED, '0, '0);
        end else begin
          depth--;
          add_report(KIND_CLOSED, stk_ord[depth], stk_line[depth]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_scan();
      awaited_reports.delete();
      fail_count = 0;
    end else begin
      // drain first: a report taken now comes from an earlier byte
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected report: kind %0d index %0d open_line %0d line %0d",
                     kind, brace_index, open_line, line);
        end else begin
          want = awaited_reports.pop_front();
          if (kind !== want.kind || brace_index !== want.idx ||
              open_line !== want.oline || line !== want.lnum) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected kind %0d index %0d open_line %0d line %0d,",
                        " got kind %0d index %0d open_line %0d line %0d"},
                       want.kind, want.idx, want.oline, want.lnum,
                       kind, brace_index, open_line, line);
          end
        end
      end
      if (in_valid && in_ready) scan_byte(first, byte_req);
    end
    pending = awaited_reports.size();
  end

endmodule

FILE: tb/sv/comment_aware_brace_matcher_tb.sv
`timescale 1ns / 1ps
// Top of the brace matcher testbench: clock, reset, source byte stimulus and verdict.
// Depends on cabm_pkg, the comment_aware_brace_matcher RTL and brace_report_checker.
module comment_aware_brace_matcher_tb;
  import cabm_pkg::*;

  localparam int ITEMS_PER_PHASE = 450;
  localparam int OPEN_BURST      = STACK_DEPTH_DEF + 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic first = 1'b0;
  logic [7:0] byte_req = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [INDEX_BITS_DEF-1:0] brace_index;
  logic [LINE_BITS_DEF-1:0]  open_line;
  logic [LINE_BITS_DEF-1:0]  line;
  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  comment_aware_brace_matcher #(
    .STACK_DEPTH (STACK_DEPTH_DEF),
    .LINE_BITS   (LINE_BITS_DEF),
    .INDEX_BITS  (INDEX_BITS_DEF)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first       (first),
    .byte_req    (byte_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .brace_index (brace_index),
    .open_line   (open_line),
    .line        (line)
  );

  brace_report_checker #(
    .STACK_DEPTH (STACK_DEPTH_DEF),
    .LINE_BITS   (LINE_BITS_DEF),
    .INDEX_BITS  (INDEX_BITS_DEF)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first       (first),
    .byte_req    (byte_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .brace_index (brace_index),
    .open_line   (open_line),
    .line        (line),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(negedge clk) begin
    out_ready = (int'($urandom_range(0, 99)) >= recv_idle);
  end

  // Weighted mix of source characters, heavy on the ones the lexer cares about.
  function automatic logic [7:0] pick_byte();
    int r;
    logic [7:0] b;
    r = int'($urandom_range(0, 99));
    case (r) inside
      [0:11]:  b = CH_LBRACE;
      [12:22]: b = CH_RBRACE;
      [23:37]: b = CH_NL;
      [38:45]: b = CH_SLASH;
      [46:51]: b = CH_STAR;
      [52:55]: b = CH_SQ;
      [56:60]: b = CH_DQ;
      [61:64]: b = CH_BSL;
      [65:92]: b = 8'($urandom_range(32, 126));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Present one word at the falling edge and hold it until it is taken.
  task automatic send_word(input logic f, input logic [7:0] b);
    @(negedge clk);
    while (int'($urandom_range(0, 99)) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    first    = f;
    byte_req = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    logic f;
    logic [7:0] b;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i < OPEN_BURST) begin
        // start a fresh file and nest past the stack depth
        f = (i == 0);
        b = (i % 8 == 7) ? CH_NL : CH_LBRACE;
      end else begin
        f = ($urandom_range(0, 249) == 0);
        b = pick_byte();
      end
      send_word(f, b);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_phase(33, 64);
    run_phase(64, 33);
    run_phase(0, 0);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // hard stop well past the longest stalled run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/cabm_pkg.sv
rtl/cabm_lexer.sv
rtl/cabm_stack_mem.sv
rtl/comment_aware_brace_matcher.sv
tb/sv/brace_report_checker.sv
tb/sv/comment_aware_brace_matcher_tb.sv
